### rtl/dnsr_pkg.sv
// ----------------------------------------------------------------------------
// dnsr_pkg
// Shared types, status codes and answer-tail table for the DNS fixed-answer
// responder.
// ----------------------------------------------------------------------------
`default_nettype none

package dnsr_pkg;

  // Header length of a DNS message in bytes
  localparam int HDR_LEN  = 12;
  // Length of the appended A-record answer
  localparam int TAIL_LEN = 16;
  // Bytes of type and class that follow the name terminator
  localparam int QTAIL_SPAN = 4;

  // Rewritten header constants
  localparam logic [7:0] FLAGS_HI = 8'h84;
  localparam logic [7:0] FLAGS_LO = 8'h00;

  // Response status codes, valid on the final item of a datagram
  typedef logic [2:0] status_t;
  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_SHORT     = 3'd1;
  localparam status_t ST_NO_QUEST  = 3'd2;
  localparam status_t ST_UNTERM    = 3'd3;
  localparam status_t ST_CUT       = 3'd4;
  localparam status_t ST_TOO_LONG  = 3'd5;

  // Input item
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  // Result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_response;
    status_t    status;
  } out_t;

  // Command from the parser to the emitter
  typedef struct packed {
    logic       has_data;  // send data first
    logic       tail;      // then send the 16-byte answer
    logic       eop;       // end flag for the data item
    logic [7:0] data;
    status_t    status;
  } cmd_t;

  // Answer tail: pointer to offset 12, type A, class IN, TTL 60, length 4,
  // then the address most significant byte first.
  function automatic logic [7:0] tail_byte(input logic [3:0] idx,
                                           input logic [31:0] addr);
    logic [7:0] r;
    begin
      case (idx)
        4'd0:    r = 8'hC0;
        4'd1:    r = 8'h0C;
        4'd2:    r = 8'h00;
        4'd3:    r = 8'h01;
        4'd4:    r = 8'h00;
        4'd5:    r = 8'h01;
        4'd6:    r = 8'h00;
        4'd7:    r = 8'h00;
        4'd8:    r = 8'h00;
        4'd9:    r = 8'h3C;
        4'd10:   r = 8'h00;
        4'd11:   r = 8'h04;
        4'd12:   r = addr[31:24];
        4'd13:   r = addr[23:16];
        4'd14:   r = addr[15:8];
        default: r = addr[7:0];
      endcase
      return r;
    end
  endfunction

endpackage

`default_nettype wire

### rtl/dnsr_fifo.sv
// ----------------------------------------------------------------------------
// dnsr_fifo
// Small register-based command queue between the parser and the emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module dnsr_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] wdata,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      rdata,
  output logic              nempty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full   = (count_r == CW'(DEPTH));
  assign nempty = (count_r != '0);
  assign rdata  = mem_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store entry
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full && !pop))
    else $error("dnsr_fifo: push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && !nempty))
    else $error("dnsr_fifo: pop from empty queue");

endmodule

`default_nettype wire

### rtl/dnsr_front.sv
// ----------------------------------------------------------------------------
// dnsr_front
// Query parser: rewrites the header, walks the label chain, trims the
// question and issues one command per kept byte and per final byte.
// ----------------------------------------------------------------------------
`default_nettype none

module dnsr_front #(
  parameter int MAX_LEN = 512
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire dnsr_pkg::in_t  in_data,
  input  wire logic           q_full,
  output logic                q_push,
  output dnsr_pkg::cmd_t      q_cmd
);

  import dnsr_pkg::*;

  localparam int IW = $clog2(MAX_LEN + 1);
  localparam int NW = $clog2(MAX_LEN);
  localparam int LW = $clog2(MAX_LEN + 257) + 1;

  logic [IW-1:0] byte_index_r, byte_index_nxt;
  logic [LW-1:0] nlp_r, nlp_nxt;
  logic [NW-1:0] nend_r, nend_nxt;
  logic          term_r, term_nxt;
  logic          qnz_r, qnz_nxt;

  logic          acc;
  logic [LW-1:0] i_x, cnt_x, nend_x;
  logic          active, hdr, hit, zb, emit;
  logic [7:0]    ob;
  status_t       st;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;

  // Classify the current byte
  always_comb begin
    i_x    = LW'(byte_index_r);
    active = (i_x < LW'(MAX_LEN));
    hdr    = (i_x < LW'(HDR_LEN));
    zb     = (in_data.data_byte == 8'd0);
    hit    = active && !hdr && !term_r && (i_x == nlp_r);

    term_nxt = term_r;
    nend_nxt = nend_r;
    nlp_nxt  = nlp_r;
    if (hit && zb) begin
      term_nxt = 1'b1;
      nend_nxt = NW'(byte_index_r);
    end else if (hit) begin
      nlp_nxt = i_x + LW'(in_data.data_byte) + LW'(1);
    end
    qnz_nxt = qnz_r || (active && !zb && (i_x == LW'(4) || i_x == LW'(5)));
    nend_x  = LW'(nend_nxt);

    // Rewrite header bytes, pass question bytes
    if (i_x < LW'(2)) begin
      ob = in_data.data_byte;
    end else if (i_x == LW'(2)) begin
      ob = FLAGS_HI;
    end else if (i_x == LW'(5) || i_x == LW'(7)) begin
      ob = 8'd1;
    end else if (hdr) begin
      ob = FLAGS_LO;
    end else begin
      ob = in_data.data_byte;
    end
    emit = active && (hdr || !term_nxt || (i_x <= nend_x + LW'(QTAIL_SPAN)));

    // Final status
    cnt_x = active ? (i_x + LW'(1)) : i_x;
    if (cnt_x < LW'(HDR_LEN)) begin
      st = ST_SHORT;
    end else if (!qnz_nxt) begin
      st = ST_NO_QUEST;
    end else if (!term_nxt) begin
      st = ST_UNTERM;
    end else if (nend_x + LW'(QTAIL_SPAN + 1) > cnt_x) begin
      st = ST_CUT;
    end else if (nend_x + LW'(QTAIL_SPAN + 1 + TAIL_LEN) > LW'(MAX_LEN)) begin
      st = ST_TOO_LONG;
    end else begin
      st = ST_OK;
    end

    // Build command
    q_cmd = '0;
    if (in_data.last_byte && st != ST_OK) begin
      q_cmd.has_data = 1'b1;
      q_cmd.eop      = 1'b1;
      q_cmd.status   = st;
    end else begin
      q_cmd.has_data = emit;
      q_cmd.tail     = in_data.last_byte;
      q_cmd.data     = ob;
      q_cmd.status   = ST_OK;
    end
    q_push = acc && (in_data.last_byte || emit);

    byte_index_nxt = active ? (byte_index_r + 1'b1) : byte_index_r;
  end

  // Hold parse state; clear at end of each datagram
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_index_r <= '0;
      nlp_r        <= LW'(HDR_LEN);
      nend_r       <= '0;
      term_r       <= 1'b0;
      qnz_r        <= 1'b0;
    end else if (acc && in_data.last_byte) begin
      byte_index_r <= '0;
      nlp_r        <= LW'(HDR_LEN);
      nend_r       <= '0;
      term_r       <= 1'b0;
      qnz_r        <= 1'b0;
    end else if (acc) begin
      byte_index_r <= byte_index_nxt;
      nlp_r        <= nlp_nxt;
      nend_r       <= nend_nxt;
      term_r       <= term_nxt;
      qnz_r        <= qnz_nxt;
    end
  end

  a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    LW'(byte_index_r) <= LW'(MAX_LEN))
    else $error("dnsr_front: byte index past limit");

  a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_data.last_byte) |=> (byte_index_r == '0 && !term_r))
    else $error("dnsr_front: state not cleared after final byte");

endmodule

`default_nettype wire

### rtl/dnsr_back.sv
// ----------------------------------------------------------------------------
// dnsr_back
// Response emitter: drains commands, sends data items and expands the
// answer tail, one result per cycle through an output register when not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module dnsr_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_nempty,
  input  wire dnsr_pkg::cmd_t  q_cmd,
  output logic                 q_pop,
  input  wire logic [31:0]     addr,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output dnsr_pkg::out_t       out_data
);

  import dnsr_pkg::*;

  logic          pend_r, pend_nxt;
  logic          tail_r, tail_nxt;
  logic [3:0]    tidx_r, tidx_nxt;
  cmd_t          cmd_r, cmd_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_t          out_data_r, out_data_nxt;

  logic          slot_free, busy, adv, last_piece;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    slot_free  = !out_valid_r || out_ready;
    busy       = pend_r || tail_r;
    adv        = slot_free && busy;
    last_piece = pend_r ? !tail_r : (tidx_r == 4'(TAIL_LEN - 1));
    q_pop      = q_nempty && (!busy || (adv && last_piece));

    pend_nxt      = pend_r;
    tail_nxt      = tail_r;
    tidx_nxt      = tidx_r;
    cmd_nxt       = cmd_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    // Emit the next piece of the current command
    if (adv) begin
      out_valid_nxt = 1'b1;
      if (pend_r) begin
        out_data_nxt.out_byte        = cmd_r.data;
        out_data_nxt.end_of_response = cmd_r.eop;
        out_data_nxt.status          = cmd_r.status;
        pend_nxt                     = 1'b0;
      end else begin
        out_data_nxt.out_byte        = tail_byte(tidx_r, addr);
        out_data_nxt.end_of_response = (tidx_r == 4'(TAIL_LEN - 1));
        out_data_nxt.status          = ST_OK;
        tidx_nxt                     = tidx_r + 4'd1;
        if (tidx_r == 4'(TAIL_LEN - 1)) begin
          tail_nxt = 1'b0;
        end
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    // Load the next command
    if (q_pop) begin
      cmd_nxt  = q_cmd;
      pend_nxt = q_cmd.has_data;
      tail_nxt = q_cmd.tail;
      tidx_nxt = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      tail_r      <= 1'b0;
      tidx_r      <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      tail_r      <= tail_nxt;
      tidx_r      <= tidx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    out_data_r <= out_data_nxt;
  end

  a_tidx_in_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (tidx_r != 4'd0) |-> tail_r)
    else $error("dnsr_back: tail index moved outside a tail");

  a_reject_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status != ST_OK) |->
      (out_data_r.end_of_response && out_data_r.out_byte == 8'd0))
    else $error("dnsr_back: malformed rejection item");

endmodule

`default_nettype wire

### rtl/dns_query_fixed_answer_responder.sv
// ----------------------------------------------------------------------------
// dns_query_fixed_answer_responder
// Streams a DNS query in and the fixed A-record response out.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one query byte per item, last_byte marks the datagram end.
//   out_*  : one response byte per item; end_of_response marks the last
//            item of a datagram, whose status is nonzero on rejection
//            (then the item carries byte 0 and earlier bytes are void).
//   cfg_*  : writes the 32-bit address returned in every answer; write it
//            only while no datagram is in flight. cfg_ready is always high.
// Throughput: one input item per cycle. The last byte of an answered query
//   expands into up to 17 result items, emitted one per cycle; a 4-entry
//   command queue between parser and emitter absorbs this and holds off
//   in_ready only while it is full.
// Path: an accepted byte's command goes through the queue, the emitter's
//   command register and then the output register to reach out_*.
// Reset: synchronous, rst_n low clears parse state, queue and output valid;
//   the address register resets to zero.
// Stall: when out_ready is low the output register holds, the queue fills
//   and then in_ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module dns_query_fixed_answer_responder #(
  parameter int MAX_LEN = 512
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire dnsr_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output dnsr_pkg::out_t      out_data,
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire logic [31:0]    cfg_data
);

  import dnsr_pkg::*;

  localparam int QDEPTH = 4;

  logic        q_push, q_pop, q_full, q_nempty;
  cmd_t        q_wcmd, q_rcmd;
  logic [31:0] addr_r;

  // Address register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= 32'd0;
    end else if (cfg_valid && cfg_ready) begin
      addr_r <= cfg_data;
    end
  end

  dnsr_front #(
    .MAX_LEN (MAX_LEN)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_wcmd)
  );

  dnsr_fifo #(
    .W     ($bits(cmd_t)),
    .DEPTH (QDEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wcmd),
    .full   (q_full),
    .pop    (q_pop),
    .rdata  (q_rcmd),
    .nempty (q_nempty)
  );

  dnsr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_nempty  (q_nempty),
    .q_cmd     (q_rcmd),
    .q_pop     (q_pop),
    .addr      (addr_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
